### src/command_table_frame_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command table frame dispatcher.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef COMMAND_TABLE_FRAME_DISPATCHER_ASSERT_SVH
`define COMMAND_TABLE_FRAME_DISPATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctfd: next-cycle check failed");

`endif

### src/ctfd_pkg.sv
// ----------------------------------------------------------------------------
// ctfd_pkg
// Shared constants and types of the command table frame dispatcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctfd_pkg;

	// Default number of table slots.
	localparam int TABLE_SLOTS_DEF = 18;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Operation codes.
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_BYTE     = 2'd1;
	localparam logic [1:0] OP_READ_END = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_REGISTERED = 3'd0;
	localparam logic [2:0] ST_ACCEPTED   = 3'd1;
	localparam logic [2:0] ST_COMPLETE   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN    = 3'd3;
	localparam logic [2:0] ST_READ_ERROR = 3'd4;
	localparam logic [2:0] ST_FULL       = 3'd5;
	localparam logic [2:0] ST_IGNORED    = 3'd6;

	// Ids with fixed home slots, and the offset of all other home slots.
	localparam logic [7:0] ID_ZERO     = 8'h00;
	localparam logic [7:0] ID_ALL_ONES = 8'hFF;
	localparam int HASH_OFFSET = 2;

	// One classified input item as it travels from the front to the back.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] cmd_id;
		logic [7:0] frame_length;
		logic [7:0] data_byte;
		logic [7:0] byte_position;
		logic       read_failed;
		logic       needs_probe;
		logic [7:0] key;
	} item_t;

endpackage

### src/command_table_frame_dispatcher.sv
// ----------------------------------------------------------------------------
// command_table_frame_dispatcher
// Hashed command table with linear probing that checks received bus bytes
// against registered frame lengths and reports one result per item.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through a queue-style port: a transfer happens when push is
// high and full is low. Results leave the same way: the oldest result sits
// on the result ports while empty is low and is taken when pop is high.
// Every item yields exactly one result, in item order.
// The front holds one item; registrations and position-zero bytes pass
// through a hash state where a reciprocal multiply yields the home slot,
// and then every item is handed on. A two-entry queue feeds the back,
// which picks up an item, probes the table one slot per cycle until it
// finds the id, a free slot or has tried every slot, and then registers
// the result. The back takes a new item only after it has registered the
// result of the last one, and so sets the rate.
// Reset clears all valid bits, the open frame, the queue and the result.
// When the receiver stalls, the result register holds its value, the back
// waits, and the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_table_frame_dispatcher #(
	parameter int TABLE_SLOTS = ctfd_pkg::TABLE_SLOTS_DEF,
	localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       op,
	input  logic [7:0]       cmd_id,
	input  logic [7:0]       frame_length,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       byte_position,
	input  logic             read_failed,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       status,
	output logic [IDX_W-1:0] slot,
	output logic [7:0]       matched_id,
	output logic [7:0]       data_out,
	output logic             frame_last
);
	import ctfd_pkg::*;

	localparam int ENTRY_W = $bits(item_t) + IDX_W;

	item_t              f_item;
	logic [IDX_W-1:0]   f_home;
	logic               f_push;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;
	item_t              b_item;
	logic [IDX_W-1:0]   b_home;

	// Front: accepts and hashes items.
	ctfd_front #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.cmd_id       (cmd_id),
		.frame_length (frame_length),
		.data_byte    (data_byte),
		.byte_position(byte_position),
		.read_failed  (read_failed),
		.item         (f_item),
		.home         (f_home),
		.q_push       (f_push),
		.q_full       (q_full)
	);

	// Queue between front and back.
	ctfd_queue #(
		.W    (ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_push),
		.wr_data({f_item, f_home}),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	assign b_item = q_data[ENTRY_W-1:IDX_W];
	assign b_home = q_data[IDX_W-1:0];

	// Back: table probe, frame tracking and result register.
	ctfd_back #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (b_item),
		.q_home    (b_home),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.slot      (slot),
		.matched_id(matched_id),
		.data_out  (data_out),
		.frame_last(frame_last)
	);

endmodule

### src/ctfd_front.sv
// ----------------------------------------------------------------------------
// ctfd_front
// Accepts input items, classifies them and computes the home slot of the
// id that a lookup or registration probes for.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctfd_front #(
	parameter int TABLE_SLOTS = ctfd_pkg::TABLE_SLOTS_DEF,
	localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          op,
	input  logic [7:0]          cmd_id,
	input  logic [7:0]          frame_length,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          byte_position,
	input  logic                read_failed,
	output ctfd_pkg::item_t     item,
	output logic [IDX_W-1:0]    home,
	output logic                q_push,
	input  logic                q_full
);
	import ctfd_pkg::*;

	// Divisor of the hash and its rounded-up reciprocal scaled by 2^16.
	// The reciprocal gives the exact quotient for every 8-bit key.
	localparam int MOD_DIV = TABLE_SLOTS - HASH_OFFSET;
	localparam logic [7:0]  MOD_DIV_B = 8'(MOD_DIV);
	localparam logic [16:0] RECIP     = 17'((65536 + MOD_DIV - 1) / MOD_DIV);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_HASH = 2'd1;
	localparam logic [1:0] F_SEND = 2'd2;

	logic [1:0]  state_q;
	item_t       item_q;
	logic [7:0]  quot_q;
	logic        accept;
	logic        needs_probe;
	logic [24:0] recip_prod;
	logic [15:0] back_prod;
	logic [7:0]  rem;

	// An input transfer happens only while no item is held.
	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign q_push = (state_q == F_SEND) && !q_full;
	assign item   = item_q;

	assign needs_probe = (op == OP_REGISTER) ||
		((op == OP_BYTE) && (byte_position == 8'd0));

	// Quotient by reciprocal multiplication, then the remainder from it.
	always_comb begin
		recip_prod = {17'd0, item_q.key} * {8'd0, RECIP};
		back_prod  = {8'd0, quot_q} * {8'd0, MOD_DIV_B};
		rem        = item_q.key - back_prod[7:0];
	end

	// Home slot: two fixed slots for the extreme ids, the remainder otherwise.
	always_comb begin
		if (item_q.key == ID_ZERO) begin
			home = '0;
		end else if (item_q.key == ID_ALL_ONES) begin
			home = IDX_W'(1);
		end else begin
			home = rem[IDX_W-1:0] + IDX_W'(HASH_OFFSET);
		end
	end

	// Sequencer: capture, hash when a probe follows, then hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= needs_probe ? F_HASH : F_SEND;
					end
				end
				F_HASH: begin
					state_q <= F_SEND;
				end
				F_SEND: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Item and quotient registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op            <= op;
			item_q.cmd_id        <= cmd_id;
			item_q.frame_length  <= frame_length;
			item_q.data_byte     <= data_byte;
			item_q.byte_position <= byte_position;
			item_q.read_failed   <= read_failed;
			item_q.needs_probe   <= needs_probe;
			item_q.key           <= (op == OP_REGISTER) ? cmd_id : data_byte;
		end else if (state_q == F_HASH) begin
			quot_q <= recip_prod[23:16];
		end
	end

endmodule

### src/ctfd_queue.sv
// ----------------------------------------------------------------------------
// ctfd_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctfd_queue #(
	parameter int W     = 8,
	parameter int DEPTH = ctfd_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	import ctfd_pkg::*;

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/ctfd_back.sv
// ----------------------------------------------------------------------------
// ctfd_back
// Holds the command table, probes it one slot per cycle, tracks the open
// frame and registers one result for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_table_frame_dispatcher_assert.svh"

module ctfd_back #(
	parameter int TABLE_SLOTS = ctfd_pkg::TABLE_SLOTS_DEF,
	localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  ctfd_pkg::item_t  q_item,
	input  logic [IDX_W-1:0] q_home,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       status,
	output logic [IDX_W-1:0] slot,
	output logic [7:0]       matched_id,
	output logic [7:0]       data_out,
	output logic             frame_last
);
	import ctfd_pkg::*;

	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_PROBE = 2'd1;
	localparam logic [1:0] B_EXEC  = 2'd2;

	logic [1:0]             state_q;
	item_t                  w_q;
	logic [IDX_W-1:0]       probe_idx_q;
	logic [CNT_W-1:0]       probe_cnt_q;
	logic                   found_q;
	logic                   table_full_q;
	logic [7:0]             slot_ids_q [TABLE_SLOTS];
	logic [7:0]             slot_lengths_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] slot_valid_q;
	logic [IDX_W-1:0]       cur_slot_q;
	logic                   frame_open_q;
	logic                   out_valid_q;

	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       rd_id;
	logic [7:0]       rd_len;
	logic             rd_valid;
	logic             len_hit;
	logic             exec_fire;
	logic             tbl_wr;
	logic             open_set;
	logic             open_clr;
	logic [2:0]       r_status;
	logic [IDX_W-1:0] r_slot;
	logic [7:0]       r_id;
	logic [7:0]       r_data;
	logic             r_last;

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign empty     = !out_valid_q;
	assign exec_fire = (state_q == B_EXEC) && (!out_valid_q || pop);

	// Single table read port: the probe index, or the open frame's slot.
	assign rd_idx   = ((state_q == B_EXEC) && !w_q.needs_probe) ? cur_slot_q : probe_idx_q;
	assign rd_id    = slot_ids_q[rd_idx];
	assign rd_len   = slot_lengths_q[rd_idx];
	assign rd_valid = slot_valid_q[rd_idx];
	assign len_hit  = (rd_len != 8'd0) && (w_q.byte_position == rd_len - 8'd1);

	// Result and state updates for the item being carried out.
	always_comb begin
		tbl_wr   = 1'b0;
		open_set = 1'b0;
		open_clr = 1'b0;
		r_status = ST_IGNORED;
		r_slot   = '0;
		r_id     = 8'd0;
		r_data   = 8'd0;
		r_last   = 1'b0;
		unique case (w_q.op)
			OP_REGISTER: begin
				r_id = w_q.cmd_id;
				if (table_full_q) begin
					r_status = ST_FULL;
				end else begin
					tbl_wr   = 1'b1;
					r_status = ST_REGISTERED;
					r_slot   = probe_idx_q;
				end
			end
			OP_BYTE: begin
				if (w_q.needs_probe && !found_q) begin
					open_clr = 1'b1;
					r_status = ST_UNKNOWN;
					r_id     = w_q.data_byte;
					r_last   = 1'b1;
				end else if (!w_q.needs_probe && !frame_open_q) begin
					r_status = ST_IGNORED;
				end else begin
					open_set = w_q.needs_probe;
					r_status = len_hit ? ST_COMPLETE : ST_ACCEPTED;
					r_slot   = rd_idx;
					r_id     = rd_id;
					r_data   = w_q.data_byte;
					r_last   = len_hit;
				end
			end
			OP_READ_END: begin
				open_clr = 1'b1;
				r_last   = 1'b1;
				if (!w_q.read_failed && frame_open_q) begin
					r_status = ST_COMPLETE;
					r_slot   = rd_idx;
					r_id     = rd_id;
				end else begin
					r_status = ST_READ_ERROR;
				end
			end
			OP_NONE: begin
				r_status = ST_IGNORED;
			end
			default: begin
				r_status = ST_IGNORED;
			end
		endcase
	end

	// Back sequencer: take an item, probe when needed, then carry it out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= q_item.needs_probe ? B_PROBE : B_EXEC;
					end
				end
				B_PROBE: begin
					if ((probe_cnt_q == CNT_W'(TABLE_SLOTS)) || !rd_valid ||
						(rd_id == w_q.key)) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (exec_fire) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Working item and probe registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			w_q         <= q_item;
			probe_idx_q <= q_home;
			probe_cnt_q <= '0;
		end else if (state_q == B_PROBE) begin
			if (probe_cnt_q == CNT_W'(TABLE_SLOTS)) begin
				found_q      <= 1'b0;
				table_full_q <= 1'b1;
			end else if (!rd_valid) begin
				found_q      <= 1'b0;
				table_full_q <= 1'b0;
			end else if (rd_id == w_q.key) begin
				found_q      <= 1'b1;
				table_full_q <= 1'b0;
			end else begin
				probe_idx_q <= (probe_idx_q == IDX_W'(TABLE_SLOTS - 1)) ?
					'0 : probe_idx_q + IDX_W'(1);
				probe_cnt_q <= probe_cnt_q + CNT_W'(1);
			end
		end
	end

	// Table entries; an entry is only read after its valid bit is set.
	always_ff @(posedge clk) begin
		if (exec_fire && tbl_wr) begin
			slot_ids_q[probe_idx_q]     <= w_q.cmd_id;
			slot_lengths_q[probe_idx_q] <= w_q.frame_length;
		end
	end

	// Valid bits, frame tracking and the output register's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			cur_slot_q   <= '0;
			frame_open_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (exec_fire) begin
				if (tbl_wr) begin
					slot_valid_q[probe_idx_q] <= 1'b1;
				end
				if (open_set) begin
					cur_slot_q   <= probe_idx_q;
					frame_open_q <= 1'b1;
				end else if (open_clr) begin
					frame_open_q <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status     <= r_status;
			slot       <= r_slot;
			matched_id <= r_id;
			data_out   <= r_data;
			frame_last <= r_last;
		end
	end

	// A probe never visits more slots than the table holds.
	`CTFD_ASSERT_IMP(a_probe_bound, clk, arst_n, state_q == B_PROBE, probe_cnt_q <= CNT_W'(TABLE_SLOTS))
	// An open frame always refers to a registered slot.
	`CTFD_ASSERT_IMP(a_open_valid, clk, arst_n, frame_open_q, slot_valid_q[cur_slot_q])
	// A waiting result is not lost until it is taken.
	`CTFD_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid_q && !pop, out_valid_q)
	// Taking an item from the queue always starts work on it.
	`CTFD_ASSERT_NEXT(a_pop_starts, clk, arst_n, q_pop, state_q != B_IDLE)

endmodule
